// ===== design/assert_macros.svh =====
// assertion macros used by the top-level design file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition implies consequence in the same cycle
`define ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// condition implies consequence in the next cycle
`define ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/bgpu_pkg.sv =====
// types and codes for the bgp update payload tagger
package bgpu_pkg;

    // parser phase, one per byte role within a section
    typedef enum logic [3:0] {
        PH_WLEN0,
        PH_WLEN1,
        PH_WPID,
        PH_WPLEN,
        PH_WPFX,
        PH_ALEN0,
        PH_ALEN1,
        PH_FLAGS,
        PH_TYPE,
        PH_AL_A,
        PH_AL_B,
        PH_VALUE,
        PH_NPID,
        PH_NPLEN,
        PH_NPFX,
        PH_DISC
    } phase_t;

    // section codes
    localparam logic [2:0] SEC_WLEN = 3'd0;
    localparam logic [2:0] SEC_WDR  = 3'd1;
    localparam logic [2:0] SEC_ALEN = 3'd2;
    localparam logic [2:0] SEC_ATTR = 3'd3;
    localparam logic [2:0] SEC_NLRI = 3'd4;
    localparam logic [2:0] SEC_DISC = 3'd5;

    // role codes
    localparam logic [3:0] ROLE_SECLEN = 4'd0;
    localparam logic [3:0] ROLE_PID    = 4'd1;
    localparam logic [3:0] ROLE_PLEN   = 4'd2;
    localparam logic [3:0] ROLE_PFX    = 4'd3;
    localparam logic [3:0] ROLE_FLAGS  = 4'd4;
    localparam logic [3:0] ROLE_TYPE   = 4'd5;
    localparam logic [3:0] ROLE_ALEN   = 4'd6;
    localparam logic [3:0] ROLE_VALUE  = 4'd7;
    localparam logic [3:0] ROLE_IGNORE = 4'd8;

    // status codes
    localparam logic [1:0] ST_BUSY    = 2'd0;
    localparam logic [1:0] ST_ACCEPT  = 2'd1;
    localparam logic [1:0] ST_OVERRUN = 2'd2;
    localparam logic [1:0] ST_EARLY   = 2'd3;

    // flag bit masks in the attribute flags byte
    localparam logic [7:0] FLAG_OPTIONAL   = 8'h80;
    localparam logic [7:0] FLAG_TRANSITIVE = 8'h40;
    localparam logic [7:0] FLAG_PARTIAL    = 8'h20;
    localparam logic [7:0] FLAG_EXTENDED   = 8'h10;

    // parser context carried from byte to byte
    typedef struct packed {
        phase_t      phase;
        logic [15:0] sec_rem;
        logic [15:0] elem_rem;
        logic [1:0]  fbi;
        logic [7:0]  len_hi;
        logic        ext;
        logic        err;
    } parse_state_t;

    // tag produced for one byte
    typedef struct packed {
        logic [2:0] section;
        logic [3:0] role;
        logic       elem_start;
        logic       elem_end;
        logic       optional_f;
        logic       transitive_f;
        logic       partial_f;
        logic       extended_f;
        logic [1:0] status;
    } tag_t;

    localparam parse_state_t PARSE_RESET = '{
        phase:    PH_WLEN0,
        sec_rem:  16'h0000,
        elem_rem: 16'h0000,
        fbi:      2'd0,
        len_hi:   8'h00,
        ext:      1'b0,
        err:      1'b0
    };

endpackage

// ===== design/bgpu_step.sv =====
// per-byte decode: tag for the byte and next parser context
module bgpu_step (
    input  bgpu_pkg::parse_state_t cur,
    input  logic                   add_path,
    input  logic [7:0]             data,
    input  logic                   eop,
    output bgpu_pkg::parse_state_t nxt,
    output bgpu_pkg::tag_t         tag
);

    logic [2:0]  sec_c;
    logic [3:0]  role_c;
    logic        start_c;
    logic        err_c;
    logic        done_c;
    logic        len_done_c;
    logic        gap_len_c;
    logic        consume_c;
    logic        gap;
    logic        any_err;
    logic [5:0]  pfx_len;
    logic [15:0] al_len;
    logic [15:0] sec_len;
    logic [15:0] rem_after;
    logic [16:0] rem17;

    // first phase of a new prefix
    function automatic bgpu_pkg::phase_t first_phase(input logic nlri, input logic ap);
        bgpu_pkg::phase_t p;
        if (ap)
        begin
            p = nlri ? bgpu_pkg::PH_NPID : bgpu_pkg::PH_WPID;
        end
        else
        begin
            p = nlri ? bgpu_pkg::PH_NPLEN : bgpu_pkg::PH_WPLEN;
        end
        return p;
    endfunction

    // length helpers
    assign pfx_len = 6'((9'(data) + 9'd7) >> 3);
    assign al_len  = (cur.phase == bgpu_pkg::PH_AL_B) ? {cur.len_hi, data} : {8'h00, data};
    assign sec_len = {cur.len_hi, data};
    assign rem17   = {1'b0, cur.sec_rem};

    // byte classification and element checks
    always_comb
    begin
        sec_c      = bgpu_pkg::SEC_DISC;
        role_c     = bgpu_pkg::ROLE_IGNORE;
        start_c    = 1'b0;
        err_c      = 1'b0;
        done_c     = 1'b0;
        len_done_c = 1'b0;
        gap_len_c  = 1'b0;
        consume_c  = 1'b0;
        unique case (cur.phase)
            bgpu_pkg::PH_WLEN0, bgpu_pkg::PH_WLEN1:
            begin
                sec_c  = bgpu_pkg::SEC_WLEN;
                role_c = bgpu_pkg::ROLE_SECLEN;
            end
            bgpu_pkg::PH_ALEN0, bgpu_pkg::PH_ALEN1:
            begin
                sec_c     = bgpu_pkg::SEC_ALEN;
                role_c    = bgpu_pkg::ROLE_SECLEN;
                gap_len_c = (cur.phase == bgpu_pkg::PH_ALEN1) && (sec_len == 16'h0000);
            end
            bgpu_pkg::PH_WPID, bgpu_pkg::PH_NPID:
            begin
                sec_c     = (cur.phase == bgpu_pkg::PH_WPID) ? bgpu_pkg::SEC_WDR
                                                             : bgpu_pkg::SEC_NLRI;
                role_c    = bgpu_pkg::ROLE_PID;
                start_c   = (cur.fbi == 2'd0);
                err_c     = (cur.phase == bgpu_pkg::PH_WPID) && (cur.fbi == 2'd0)
                            && (cur.sec_rem < 16'd5);
                consume_c = (cur.phase == bgpu_pkg::PH_WPID) && !err_c;
            end
            bgpu_pkg::PH_WPLEN, bgpu_pkg::PH_NPLEN:
            begin
                sec_c     = (cur.phase == bgpu_pkg::PH_WPLEN) ? bgpu_pkg::SEC_WDR
                                                              : bgpu_pkg::SEC_NLRI;
                role_c    = bgpu_pkg::ROLE_PLEN;
                start_c   = (cur.fbi == 2'd1);
                err_c     = (cur.phase == bgpu_pkg::PH_WPLEN)
                            && (rem17 < (17'(pfx_len) + 17'd1));
                consume_c = (cur.phase == bgpu_pkg::PH_WPLEN) && !err_c;
                done_c    = !err_c && (pfx_len == 6'd0);
            end
            bgpu_pkg::PH_WPFX, bgpu_pkg::PH_NPFX:
            begin
                sec_c     = (cur.phase == bgpu_pkg::PH_WPFX) ? bgpu_pkg::SEC_WDR
                                                             : bgpu_pkg::SEC_NLRI;
                role_c    = bgpu_pkg::ROLE_PFX;
                consume_c = (cur.phase == bgpu_pkg::PH_WPFX);
                done_c    = (cur.elem_rem == 16'd1);
            end
            bgpu_pkg::PH_FLAGS:
            begin
                sec_c     = bgpu_pkg::SEC_ATTR;
                role_c    = bgpu_pkg::ROLE_FLAGS;
                start_c   = 1'b1;
                err_c     = ((data & bgpu_pkg::FLAG_EXTENDED) != 8'h00)
                            ? (cur.sec_rem < 16'd4) : (cur.sec_rem < 16'd3);
                consume_c = !err_c;
            end
            bgpu_pkg::PH_TYPE:
            begin
                sec_c     = bgpu_pkg::SEC_ATTR;
                role_c    = bgpu_pkg::ROLE_TYPE;
                consume_c = 1'b1;
            end
            bgpu_pkg::PH_AL_A, bgpu_pkg::PH_AL_B:
            begin
                sec_c  = bgpu_pkg::SEC_ATTR;
                role_c = bgpu_pkg::ROLE_ALEN;
                if ((cur.phase == bgpu_pkg::PH_AL_A) && cur.ext)
                begin
                    consume_c = 1'b1;
                end
                else
                begin
                    err_c      = rem17 < ({1'b0, al_len} + 17'd1);
                    consume_c  = !err_c;
                    len_done_c = !err_c && (al_len == 16'h0000);
                end
            end
            bgpu_pkg::PH_VALUE:
            begin
                sec_c      = bgpu_pkg::SEC_ATTR;
                role_c     = bgpu_pkg::ROLE_VALUE;
                consume_c  = 1'b1;
                len_done_c = (cur.elem_rem == 16'd1);
            end
            default:
            begin
                sec_c  = bgpu_pkg::SEC_DISC;
                role_c = bgpu_pkg::ROLE_IGNORE;
            end
        endcase
    end

    // section count after this byte
    always_comb
    begin
        if ((cur.phase == bgpu_pkg::PH_WLEN1) || (cur.phase == bgpu_pkg::PH_ALEN1))
        begin
            rem_after = sec_len;
        end
        else if (consume_c)
        begin
            rem_after = cur.sec_rem - 16'd1;
        end
        else
        begin
            rem_after = cur.sec_rem;
        end
    end

    // byte leaves the parser between two nlri prefixes
    assign gap = gap_len_c || (done_c && (sec_c == bgpu_pkg::SEC_NLRI))
                 || (len_done_c && (rem_after == 16'h0000));
    assign any_err = cur.err || err_c;

    // next parser context
    always_comb
    begin
        nxt         = cur;
        nxt.sec_rem = rem_after;
        unique case (cur.phase)
            bgpu_pkg::PH_WLEN0:
            begin
                nxt.len_hi = data;
                nxt.phase  = bgpu_pkg::PH_WLEN1;
            end
            bgpu_pkg::PH_ALEN0:
            begin
                nxt.len_hi = data;
                nxt.phase  = bgpu_pkg::PH_ALEN1;
            end
            bgpu_pkg::PH_WLEN1:
            begin
                if (rem_after == 16'h0000)
                begin
                    nxt.phase = bgpu_pkg::PH_ALEN0;
                end
                else
                begin
                    nxt.phase = first_phase(1'b0, add_path);
                    nxt.fbi   = {1'b0, ~add_path};
                end
            end
            bgpu_pkg::PH_ALEN1:
            begin
                if (rem_after == 16'h0000)
                begin
                    nxt.phase = first_phase(1'b1, add_path);
                    nxt.fbi   = {1'b0, ~add_path};
                end
                else
                begin
                    nxt.phase = bgpu_pkg::PH_FLAGS;
                end
            end
            bgpu_pkg::PH_WPID, bgpu_pkg::PH_NPID:
            begin
                if (cur.fbi == 2'd3)
                begin
                    nxt.fbi   = 2'd0;
                    nxt.phase = (cur.phase == bgpu_pkg::PH_WPID) ? bgpu_pkg::PH_WPLEN
                                                                 : bgpu_pkg::PH_NPLEN;
                end
                else
                begin
                    nxt.fbi = cur.fbi + 2'd1;
                end
            end
            bgpu_pkg::PH_WPLEN, bgpu_pkg::PH_NPLEN:
            begin
                if (pfx_len != 6'd0)
                begin
                    nxt.elem_rem = 16'(pfx_len);
                    nxt.phase    = (cur.phase == bgpu_pkg::PH_WPLEN) ? bgpu_pkg::PH_WPFX
                                                                     : bgpu_pkg::PH_NPFX;
                end
            end
            bgpu_pkg::PH_WPFX, bgpu_pkg::PH_NPFX, bgpu_pkg::PH_VALUE:
            begin
                nxt.elem_rem = cur.elem_rem - 16'd1;
            end
            bgpu_pkg::PH_FLAGS:
            begin
                nxt.ext   = (data & bgpu_pkg::FLAG_EXTENDED) != 8'h00;
                nxt.phase = bgpu_pkg::PH_TYPE;
            end
            bgpu_pkg::PH_TYPE:
            begin
                nxt.phase = bgpu_pkg::PH_AL_A;
            end
            bgpu_pkg::PH_AL_A, bgpu_pkg::PH_AL_B:
            begin
                if ((cur.phase == bgpu_pkg::PH_AL_A) && cur.ext)
                begin
                    nxt.len_hi = data;
                    nxt.phase  = bgpu_pkg::PH_AL_B;
                end
                else if (al_len != 16'h0000)
                begin
                    nxt.elem_rem = al_len;
                    nxt.phase    = bgpu_pkg::PH_VALUE;
                end
            end
            default:
            begin
                nxt.phase = bgpu_pkg::PH_DISC;
            end
        endcase

        // element completion and overrun override the phase step
        if (err_c)
        begin
            nxt.err   = 1'b1;
            nxt.phase = bgpu_pkg::PH_DISC;
        end
        else if (done_c)
        begin
            if (sec_c == bgpu_pkg::SEC_NLRI)
            begin
                nxt.phase = first_phase(1'b1, add_path);
                nxt.fbi   = {1'b0, ~add_path};
            end
            else if (rem_after == 16'h0000)
            begin
                nxt.phase = bgpu_pkg::PH_ALEN0;
            end
            else
            begin
                nxt.phase = first_phase(1'b0, add_path);
                nxt.fbi   = {1'b0, ~add_path};
            end
        end
        else if (len_done_c)
        begin
            if (rem_after == 16'h0000)
            begin
                nxt.phase = first_phase(1'b1, add_path);
                nxt.fbi   = {1'b0, ~add_path};
            end
            else
            begin
                nxt.phase = bgpu_pkg::PH_FLAGS;
            end
        end

        // end of payload starts a fresh message
        if (eop)
        begin
            nxt = bgpu_pkg::PARSE_RESET;
        end
    end

    // tag outputs
    always_comb
    begin
        tag              = '0;
        tag.section      = sec_c;
        tag.role         = role_c;
        tag.elem_start   = start_c;
        tag.elem_end     = done_c || len_done_c;
        if (cur.phase == bgpu_pkg::PH_FLAGS)
        begin
            tag.optional_f   = (data & bgpu_pkg::FLAG_OPTIONAL) != 8'h00;
            tag.transitive_f = (data & bgpu_pkg::FLAG_TRANSITIVE) != 8'h00;
            tag.partial_f    = (data & bgpu_pkg::FLAG_PARTIAL) != 8'h00;
            tag.extended_f   = (data & bgpu_pkg::FLAG_EXTENDED) != 8'h00;
        end
        if (any_err)
        begin
            tag.status = bgpu_pkg::ST_OVERRUN;
        end
        else if (!eop)
        begin
            tag.status = bgpu_pkg::ST_BUSY;
        end
        else if (gap)
        begin
            tag.status = bgpu_pkg::ST_ACCEPT;
        end
        else
        begin
            tag.status = bgpu_pkg::ST_EARLY;
        end
    end

endmodule

// ===== design/bgp_update_message_parser.sv =====
// Top level of the bgp update payload tagger: input register, decode, result register.
// An accepted request waits in the input register, is decoded, and is then captured in the result register.
// Throughput: one byte per cycle while the result side does not stall; the parser context updates with each byte.
// A stalled result holds the result register; the input register then fills and stalls.
// Reset clears the valid flags, the parser context and add_path_reg at once.
`include "assert_macros.svh"

module bgp_update_message_parser (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_write,
    input  logic       cfg_data,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] data_byte,
    input  logic       end_of_payload,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] byte_value,
    output logic [2:0] section,
    output logic [3:0] role,
    output logic       element_start,
    output logic       element_end,
    output logic       attr_optional,
    output logic       attr_transitive,
    output logic       attr_partial,
    output logic       attr_extended,
    output logic [1:0] status,
    output logic       message_end
);

    logic                   add_path_reg;
    logic                   in_vld_reg;
    logic                   in_vld_next;
    logic [7:0]             in_data_reg;
    logic                   in_eop_reg;
    logic                   out_vld_reg;
    logic                   out_vld_next;
    logic [7:0]             out_data_reg;
    logic                   out_eop_reg;
    bgpu_pkg::tag_t         out_tag_reg;
    bgpu_pkg::parse_state_t state_reg;
    bgpu_pkg::parse_state_t state_next;
    bgpu_pkg::tag_t         tag_next;
    logic                   advance;
    logic                   in_take;

    // handshake control
    assign advance = in_vld_reg && (!out_vld_reg || !out_stall);
    assign in_stall = in_vld_reg && !advance;
    assign in_take = in_valid && !in_stall;

    assign in_vld_next  = in_take ? 1'b1 : (advance ? 1'b0 : in_vld_reg);
    assign out_vld_next = advance ? 1'b1 : ((out_vld_reg && !out_stall) ? 1'b0 : out_vld_reg);

    // per-byte decode
    bgpu_step u_step (
        .cur      (state_reg),
        .add_path (add_path_reg),
        .data     (in_data_reg),
        .eop      (in_eop_reg),
        .nxt      (state_next),
        .tag      (tag_next)
    );

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            add_path_reg <= 1'b0;
            in_vld_reg   <= 1'b0;
            out_vld_reg  <= 1'b0;
            state_reg    <= bgpu_pkg::PARSE_RESET;
        end
        else
        begin
            if (cfg_write)
            begin
                add_path_reg <= cfg_data;
            end
            in_vld_reg  <= in_vld_next;
            out_vld_reg <= out_vld_next;
            if (advance)
            begin
                state_reg <= state_next;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            in_data_reg <= data_byte;
            in_eop_reg  <= end_of_payload;
        end
        if (advance)
        begin
            out_data_reg <= in_data_reg;
            out_eop_reg  <= in_eop_reg;
            out_tag_reg  <= tag_next;
        end
    end

    // result ports
    assign out_valid       = out_vld_reg;
    assign byte_value      = out_data_reg;
    assign section         = out_tag_reg.section;
    assign role            = out_tag_reg.role;
    assign element_start   = out_tag_reg.elem_start;
    assign element_end     = out_tag_reg.elem_end;
    assign attr_optional   = out_tag_reg.optional_f;
    assign attr_transitive = out_tag_reg.transitive_f;
    assign attr_partial    = out_tag_reg.partial_f;
    assign attr_extended   = out_tag_reg.extended_f;
    assign status          = out_tag_reg.status;
    assign message_end     = out_eop_reg;

    // checks
    `ASSERT_NEXT(a_eop_clears, advance && in_eop_reg,
        (state_reg.phase == bgpu_pkg::PH_WLEN0) && !state_reg.err,
        "context not cleared after end of payload")
    `ASSERT_NEXT(a_err_sticky, advance && state_reg.err && !in_eop_reg,
        state_reg.err, "overrun flag dropped within a payload")
    `ASSERT_SAME(a_disc_status, out_valid && (section == bgpu_pkg::SEC_DISC),
        status == bgpu_pkg::ST_OVERRUN, "discarded byte without overrun status")
    `ASSERT_SAME(a_end_section, out_valid && element_end,
        (section == bgpu_pkg::SEC_WDR) || (section == bgpu_pkg::SEC_ATTR)
        || (section == bgpu_pkg::SEC_NLRI), "element end outside an element section")

endmodule

// ===== dv/tb_bgp_update_message_parser.sv =====
// testbench for the bgp update payload tagger: byte predictor, scoreboard and random payloads
module tb_bgp_update_message_parser;

    // expected tag for one payload byte
    typedef struct packed {
        logic [7:0]     value;
        bgpu_pkg::tag_t tag;
        logic           last;
    } byte_tag_t;

    // byte-by-byte tag predictor with a queue of expected tags
    class payload_tag_board;
        bit                add_path;
        bgpu_pkg::phase_t  ph;
        bit [15:0]         sec_left;
        bit [15:0]         elem_left;
        bit [1:0]          fidx;
        bit [7:0]          len_hi;
        bit                ext_len;
        bit [1:0]          sticky;
        byte_tag_t         pending_tags[$];
        int                mismatches;
        int                bytes_seen;
        int                msg_count;
        int                ok_count;
        int                overrun_count;
        int                early_count;

        function new();
            add_path = 1'b0;
            clear_parse();
        endfunction

        function void clear_parse();
            ph        = bgpu_pkg::PH_WLEN0;
            sec_left  = '0;
            elem_left = '0;
            fidx      = '0;
            len_hi    = '0;
            ext_len   = 1'b0;
            sticky    = bgpu_pkg::ST_BUSY;
        endfunction

        // first byte of a prefix: path id when add-path is on, else the length byte
        function void begin_prefix(bit nlri);
            if (add_path) begin
                ph   = nlri ? bgpu_pkg::PH_NPID : bgpu_pkg::PH_WPID;
                fidx = 2'd0;
            end
            else begin
                ph   = nlri ? bgpu_pkg::PH_NPLEN : bgpu_pkg::PH_WPLEN;
                fidx = 2'd1;
            end
        endfunction

        function int pending();
            return pending_tags.size();
        endfunction

        // work out the tag of one accepted request
        function void note_request(logic [7:0] b, logic last);
            byte_tag_t e;
            int        left;
            int        nbytes;
            int        vlen;
            bit        counted;
            bit        overrun;
            bit        gap;
            bit        pfx_done;
            bit        attr_done;
            e             = '0;
            e.value       = b;
            e.last        = last;
            e.tag.section = bgpu_pkg::SEC_DISC;
            e.tag.role    = bgpu_pkg::ROLE_IGNORE;
            left          = int'(sec_left);
            overrun       = 1'b0;
            gap           = 1'b0;
            pfx_done      = 1'b0;
            attr_done     = 1'b0;
            case (ph)
                bgpu_pkg::PH_WLEN0, bgpu_pkg::PH_WLEN1, bgpu_pkg::PH_ALEN0, bgpu_pkg::PH_ALEN1:
                begin
                    e.tag.section = (ph == bgpu_pkg::PH_WLEN0 || ph == bgpu_pkg::PH_WLEN1)
                                    ? bgpu_pkg::SEC_WLEN : bgpu_pkg::SEC_ALEN;
                    e.tag.role    = bgpu_pkg::ROLE_SECLEN;
                    if (ph == bgpu_pkg::PH_WLEN0 || ph == bgpu_pkg::PH_ALEN0)
                    begin
                        len_hi = b;
                        ph     = (ph == bgpu_pkg::PH_WLEN0) ? bgpu_pkg::PH_WLEN1
                                                            : bgpu_pkg::PH_ALEN1;
                    end
                    else
                    begin
                        sec_left = {len_hi, b};
                        if (ph == bgpu_pkg::PH_WLEN1)
                        begin
                            if (sec_left == 0)
                                ph = bgpu_pkg::PH_ALEN0;
                            else
                                begin_prefix(1'b0);
                        end
                        else if (sec_left == 0)
                        begin
                            begin_prefix(1'b1);
                            gap = 1'b1;
                        end
                        else
                            ph = bgpu_pkg::PH_FLAGS;
                    end
                end
                bgpu_pkg::PH_WPID, bgpu_pkg::PH_NPID:
                begin
                    counted       = (ph == bgpu_pkg::PH_WPID);
                    e.tag.section = counted ? bgpu_pkg::SEC_WDR : bgpu_pkg::SEC_NLRI;
                    e.tag.role    = bgpu_pkg::ROLE_PID;
                    if (fidx == 0)
                    begin
                        e.tag.elem_start = 1'b1;
                        if (counted && left < 5)
                            overrun = 1'b1;
                    end
                    if (!overrun)
                    begin
                        if (counted)
                            sec_left--;
                        if (fidx == 3)
                        begin
                            fidx = 2'd0;
                            ph   = counted ? bgpu_pkg::PH_WPLEN : bgpu_pkg::PH_NPLEN;
                        end
                        else
                            fidx++;
                    end
                end
                bgpu_pkg::PH_WPLEN, bgpu_pkg::PH_NPLEN:
                begin
                    counted          = (ph == bgpu_pkg::PH_WPLEN);
                    e.tag.section    = counted ? bgpu_pkg::SEC_WDR : bgpu_pkg::SEC_NLRI;
                    e.tag.role       = bgpu_pkg::ROLE_PLEN;
                    e.tag.elem_start = (fidx == 1);
                    nbytes           = (int'(b) + 7) / 8;
                    if (counted && left < nbytes + 1)
                        overrun = 1'b1;
                    else
                    begin
                        if (counted)
                            sec_left--;
                        if (nbytes == 0)
                            pfx_done = 1'b1;
                        else
                        begin
                            elem_left = 16'(nbytes);
                            ph        = counted ? bgpu_pkg::PH_WPFX : bgpu_pkg::PH_NPFX;
                        end
                    end
                end
                bgpu_pkg::PH_WPFX, bgpu_pkg::PH_NPFX:
                begin
                    counted       = (ph == bgpu_pkg::PH_WPFX);
                    e.tag.section = counted ? bgpu_pkg::SEC_WDR : bgpu_pkg::SEC_NLRI;
                    e.tag.role    = bgpu_pkg::ROLE_PFX;
                    if (counted)
                        sec_left--;
                    elem_left--;
                    if (elem_left == 0)
                        pfx_done = 1'b1;
                end
                bgpu_pkg::PH_FLAGS:
                begin
                    e.tag.section      = bgpu_pkg::SEC_ATTR;
                    e.tag.role         = bgpu_pkg::ROLE_FLAGS;
                    e.tag.elem_start   = 1'b1;
                    e.tag.optional_f   = (b & bgpu_pkg::FLAG_OPTIONAL) != 0;
                    e.tag.transitive_f = (b & bgpu_pkg::FLAG_TRANSITIVE) != 0;
                    e.tag.partial_f    = (b & bgpu_pkg::FLAG_PARTIAL) != 0;
                    e.tag.extended_f   = (b & bgpu_pkg::FLAG_EXTENDED) != 0;
                    ext_len            = (b & bgpu_pkg::FLAG_EXTENDED) != 0;
                    if (left < (ext_len ? 4 : 3))
                        overrun = 1'b1;
                    else
                    begin
                        sec_left--;
                        ph = bgpu_pkg::PH_TYPE;
                    end
                end
                bgpu_pkg::PH_TYPE:
                begin
                    e.tag.section = bgpu_pkg::SEC_ATTR;
                    e.tag.role    = bgpu_pkg::ROLE_TYPE;
                    sec_left--;
                    ph = bgpu_pkg::PH_AL_A;
                end
                bgpu_pkg::PH_AL_A, bgpu_pkg::PH_AL_B:
                begin
                    e.tag.section = bgpu_pkg::SEC_ATTR;
                    e.tag.role    = bgpu_pkg::ROLE_ALEN;
                    if (ph == bgpu_pkg::PH_AL_A && ext_len)
                    begin
                        sec_left--;
                        len_hi = b;
                        ph     = bgpu_pkg::PH_AL_B;
                    end
                    else
                    begin
                        vlen = (ph == bgpu_pkg::PH_AL_B) ? int'({len_hi, b}) : int'(b);
                        if (left < vlen + 1)
                            overrun = 1'b1;
                        else
                        begin
                            sec_left--;
                            if (vlen == 0)
                                attr_done = 1'b1;
                            else
                            begin
                                elem_left = 16'(vlen);
                                ph        = bgpu_pkg::PH_VALUE;
                            end
                        end
                    end
                end
                bgpu_pkg::PH_VALUE:
                begin
                    e.tag.section = bgpu_pkg::SEC_ATTR;
                    e.tag.role    = bgpu_pkg::ROLE_VALUE;
                    sec_left--;
                    elem_left--;
                    if (elem_left == 0)
                        attr_done = 1'b1;
                end
                default:
                begin
                end
            endcase

            // element completion and the next phase
            if (overrun)
            begin
                sticky = bgpu_pkg::ST_OVERRUN;
                ph     = bgpu_pkg::PH_DISC;
            end
            else if (pfx_done)
            begin
                e.tag.elem_end = 1'b1;
                if (e.tag.section == bgpu_pkg::SEC_NLRI)
                begin
                    begin_prefix(1'b1);
                    gap = 1'b1;
                end
                else if (sec_left == 0)
                    ph = bgpu_pkg::PH_ALEN0;
                else
                    begin_prefix(1'b0);
            end
            else if (attr_done)
            begin
                e.tag.elem_end = 1'b1;
                if (sec_left == 0)
                begin
                    begin_prefix(1'b1);
                    gap = 1'b1;
                end
                else
                    ph = bgpu_pkg::PH_FLAGS;
            end

            // status, and a fresh parse after the last byte
            if (last)
            begin
                e.tag.status = (sticky != bgpu_pkg::ST_BUSY) ? sticky
                               : (gap ? bgpu_pkg::ST_ACCEPT : bgpu_pkg::ST_EARLY);
                msg_count++;
                if (e.tag.status == bgpu_pkg::ST_ACCEPT)
                    ok_count++;
                else if (e.tag.status == bgpu_pkg::ST_OVERRUN)
                    overrun_count++;
                else
                    early_count++;
                clear_parse();
            end
            else
                e.tag.status = sticky;
            bytes_seen++;
            pending_tags = {pending_tags, e};
        endfunction

        function void compare_field(string name, logic [15:0] exp, logic [15:0] act);
            if (act !== exp)
            begin
                mismatches++;
                if (mismatches <= 40)
                    $display("%0t: %s mismatch, expected %0d got %0d", $time, name, exp, act);
            end
        endfunction

        // compare one accepted result with the oldest expected tag
        function void check_tag(byte_tag_t act);
            byte_tag_t exp;
            if (pending_tags.size() == 0)
            begin
                mismatches++;
                $display("%0t: result with no request pending, expected none got byte %0d",
                         $time, act.value);
                return;
            end
            exp = pending_tags.pop_front();
            compare_field("byte_value", 16'(exp.value), 16'(act.value));
            compare_field("section", 16'(exp.tag.section), 16'(act.tag.section));
            compare_field("role", 16'(exp.tag.role), 16'(act.tag.role));
            compare_field("element_start", 16'(exp.tag.elem_start), 16'(act.tag.elem_start));
            compare_field("element_end", 16'(exp.tag.elem_end), 16'(act.tag.elem_end));
            compare_field("attr_optional", 16'(exp.tag.optional_f), 16'(act.tag.optional_f));
            compare_field("attr_transitive", 16'(exp.tag.transitive_f),
                          16'(act.tag.transitive_f));
            compare_field("attr_partial", 16'(exp.tag.partial_f), 16'(act.tag.partial_f));
            compare_field("attr_extended", 16'(exp.tag.extended_f), 16'(act.tag.extended_f));
            compare_field("status", 16'(exp.tag.status), 16'(act.tag.status));
            compare_field("message_end", 16'(exp.last), 16'(act.last));
        endfunction
    endclass

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       cfg_write = 1'b0;
    logic       cfg_data = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_stall;
    logic [7:0] data_byte = 8'h00;
    logic       end_of_payload = 1'b0;
    logic       out_valid;
    logic       out_stall = 1'b0;
    logic [7:0] byte_value;
    logic [2:0] section;
    logic [3:0] role;
    logic       element_start;
    logic       element_end;
    logic       attr_optional;
    logic       attr_transitive;
    logic       attr_partial;
    logic       attr_extended;
    logic [1:0] status;
    logic       message_end;

    payload_tag_board board = new();

    bit [7:0] pkt[$];
    bit [7:0] part_q[$];
    bit       add_path_now = 1'b0;
    bit       gappy = 1'b0;
    int       burst_left = 0;
    int       settings_used = 0;
    int       stall_mode = 0;
    int       stall_span = 0;
    int       cycle_count = 0;

    bgp_update_message_parser u_dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_write       (cfg_write),
        .cfg_data        (cfg_data),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .data_byte       (data_byte),
        .end_of_payload  (end_of_payload),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .byte_value      (byte_value),
        .section         (section),
        .role            (role),
        .element_start   (element_start),
        .element_end     (element_end),
        .attr_optional   (attr_optional),
        .attr_transitive (attr_transitive),
        .attr_partial    (attr_partial),
        .attr_extended   (attr_extended),
        .status          (status),
        .message_end     (message_end)
    );

    // clock
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // receiver stall pattern: free, light, heavy or periodic stretches
    always @(posedge clk)
    begin
        if (stall_span == 0)
        begin
            stall_mode = $urandom_range(0, 3);
            stall_span = $urandom_range(20, 200);
        end
        stall_span--;
        cycle_count++;
        case (stall_mode)
            0:       out_stall <= 1'b0;
            1:       out_stall <= ($urandom_range(0, 3) == 0);
            2:       out_stall <= ($urandom_range(0, 3) != 0);
            default: out_stall <= (cycle_count % 5 < 2);
        endcase
    end

    // result monitor: outputs are stable at the falling edge before the accepting edge
    always @(negedge clk)
    begin
        byte_tag_t act;
        if (rst_n && out_valid && !out_stall)
        begin
            act.value            = byte_value;
            act.tag.section      = section;
            act.tag.role         = role;
            act.tag.elem_start   = element_start;
            act.tag.elem_end     = element_end;
            act.tag.optional_f   = attr_optional;
            act.tag.transitive_f = attr_transitive;
            act.tag.partial_f    = attr_partial;
            act.tag.extended_f   = attr_extended;
            act.tag.status       = status;
            act.last             = message_end;
            board.check_tag(act);
        end
    end

    // one byte request, with bursts and gaps on the sender side
    task automatic send_byte(input bit [7:0] b, input bit last);
        int gap;
        bit go;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 16);
            gap = gappy ? $urandom_range(1, 6) : 0;
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        in_valid       <= 1'b1;
        data_byte      <= b;
        end_of_payload <= last;
        do
        begin
            @(negedge clk);
            go = !in_stall;
            @(posedge clk);
        end
        while (!go);
        board.note_request(b, last);
        burst_left--;
    endtask

    task automatic send_payload();
        gappy = ($urandom_range(0, 3) != 0);
        foreach (pkt[i])
            send_byte(pkt[i], i == pkt.size() - 1);
    endtask

    // hold requests until every expected tag has come back
    task automatic drain();
        in_valid <= 1'b0;
        burst_left = 0;
        while (board.pending() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_add_path(input bit v);
        drain();
        cfg_write <= 1'b1;
        cfg_data  <= v;
        @(posedge clk);
        cfg_write <= 1'b0;
        board.add_path = v;
        add_path_now   = v;
        settings_used++;
    endtask

    // prefix: optional path id, length byte, ceil(len/8) bytes
    function automatic void put_prefix();
        int plen;
        int pick;
        if (add_path_now)
            repeat (4) part_q = {part_q, 8'($urandom)};
        pick = $urandom_range(0, 9);
        if (pick < 7)
            plen = $urandom_range(0, 32);
        else if (pick < 9)
            plen = $urandom_range(33, 128);
        else
            plen = $urandom_range(129, 255);
        part_q = {part_q, 8'(plen)};
        repeat ((plen + 7) / 8) part_q = {part_q, 8'($urandom)};
    endfunction

    // attribute: flags, type, 1- or 2-byte length, value
    function automatic void put_attr();
        bit [7:0] fl;
        int       vlen;
        fl = 8'($urandom);
        if ((fl & bgpu_pkg::FLAG_EXTENDED) != 0)
            vlen = ($urandom_range(0, 9) == 0) ? $urandom_range(256, 300) : $urandom_range(0, 6);
        else
            vlen = ($urandom_range(0, 29) == 0) ? $urandom_range(9, 200) : $urandom_range(0, 8);
        part_q = {part_q, fl};
        part_q = {part_q, 8'($urandom)};
        if ((fl & bgpu_pkg::FLAG_EXTENDED) != 0)
            part_q = {part_q, 8'(vlen >> 8)};
        part_q = {part_q, 8'(vlen)};
        repeat (vlen) part_q = {part_q, 8'($urandom)};
    endfunction

    // mostly well-formed updates; some cut short, corrupted or plain noise
    function automatic void build_payload();
        bit [7:0] wd[$];
        bit [7:0] at[$];
        int       mode;
        int       cut;
        int       pos;
        part_q = {};
        repeat ($urandom_range(0, 2)) put_prefix();
        wd = part_q;
        part_q = {};
        repeat ($urandom_range(0, 3)) put_attr();
        at = part_q;
        part_q = {};
        repeat ($urandom_range(0, 3)) put_prefix();
        pkt = {};
        pkt = {pkt, 8'(wd.size() >> 8)};
        pkt = {pkt, 8'(wd.size())};
        pkt = {pkt, wd};
        pkt = {pkt, 8'(at.size() >> 8)};
        pkt = {pkt, 8'(at.size())};
        pkt = {pkt, at, part_q};
        mode = $urandom_range(0, 99);
        if (mode >= 70 && mode < 80)
        begin
            cut = $urandom_range(1, pkt.size() - 1);
            while (pkt.size() > cut)
                void'(pkt.pop_back());
        end
        else if (mode >= 80 && mode < 90)
        begin
            pos = $urandom_range(0, pkt.size() - 1);
            pkt[pos] ^= 8'($urandom_range(1, 255));
        end
        else if (mode >= 90)
        begin
            pkt = {};
            repeat ($urandom_range(1, 10)) pkt = {pkt, 8'($urandom)};
        end
    endfunction

    // run limit
    initial
    begin
        #4_800_000;
        $display("bgp_update_message_parser verification failed");
        $finish;
    end

    // main sequence
    initial
    begin
        int payloads;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty sections, then one nlri prefix with a path id
        write_add_path(1'b1);
        pkt = '{8'h00, 8'h00, 8'h00, 8'h00, 8'h01, 8'h02, 8'h03, 8'h04, 8'h00};
        send_payload();

        // zero-length withdrawn prefix, extended zero-length attribute, one nlri prefix
        write_add_path(1'b0);
        pkt = '{8'h00, 8'h01, 8'h00, 8'h00, 8'h04, 8'hF0, 8'hFF, 8'h00, 8'h00,
                8'h08, 8'hFF};
        send_payload();

        // withdrawn prefix overruns its section, next byte discarded
        pkt = '{8'h00, 8'h02, 8'h20, 8'hAB};
        send_payload();

        // payload ends inside the withdrawn routes section
        pkt = '{8'h00, 8'h05};
        send_payload();

        // random payloads with add-path changes between some of them
        payloads = 0;
        while (board.bytes_seen < 1550)
        begin
            if (payloads % 8 == 7)
                write_add_path($urandom_range(0, 1));
            build_payload();
            send_payload();
            payloads++;
        end

        // wait out the remaining results
        in_valid <= 1'b0;
        while (board.pending() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);

        $display("sent %0d payload bytes in %0d payloads over %0d add-path settings",
                 board.bytes_seen, board.msg_count, settings_used);
        $display("payload endings: %0d accepted, %0d overrun, %0d ended early",
                 board.ok_count, board.overrun_count, board.early_count);
        if (board.mismatches == 0)
            $display("bgp_update_message_parser verification clean");
        else
            $display("bgp_update_message_parser verification failed");
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+design
design/bgpu_pkg.sv
design/bgpu_step.sv
design/bgp_update_message_parser.sv
dv/tb_bgp_update_message_parser.sv
